FILE: rtl/spi_nor_flash_command_sequencer_macros.svh
// Assertion helpers shared by the sequencer modules.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define SNF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define SNF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/snf_pkg.sv
`default_nettype none

package snf_pkg;

   localparam int PageBytes     = 256;
   localparam int PageCntWidth  = 9;
   localparam int MaxResults    = 10;
   localparam int CountWidth    = 4;

   // Host commands.
   localparam logic [2:0] CMD_READ    = 3'd0;
   localparam logic [2:0] CMD_PROGRAM = 3'd1;
   localparam logic [2:0] CMD_ERASE   = 3'd2;
   localparam logic [2:0] CMD_DATA    = 3'd3;
   localparam logic [2:0] CMD_RXBYTE  = 3'd4;

   // Result kinds.
   localparam logic [2:0] KIND_SEL    = 3'd0;
   localparam logic [2:0] KIND_SEND   = 3'd1;
   localparam logic [2:0] KIND_DESEL  = 3'd2;
   localparam logic [2:0] KIND_DATA   = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;
   localparam logic [2:0] KIND_REJECT = 3'd5;

   // Flash opcodes.
   localparam logic [7:0] OPC_WREN    = 8'h06;
   localparam logic [7:0] OPC_PROGRAM = 8'h02;
   localparam logic [7:0] OPC_ERASE   = 8'h20;
   localparam logic [7:0] OPC_READ    = 8'h03;
   localparam logic [7:0] OPC_RDSR    = 8'h05;
   localparam logic [7:0] DUMMY_BYTE  = 8'h00;

   // Operation in progress.
   localparam logic [1:0] OP_READ     = 2'd0;
   localparam logic [1:0] OP_PROGRAM  = 2'd1;
   localparam logic [1:0] OP_ERASE    = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
   } entry_type;

   // Words produced by one request; entry 0 goes out first.
   typedef struct packed {
      entry_type [MaxResults-1:0] entry;
      logic [CountWidth-1:0]      count;
   } batch_type;

   function automatic entry_type make_entry(input logic [2:0] kind, input logic [7:0] value);
      entry_type e;
      e.kind  = kind;
      e.value = value;
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/snf_decoder.sv
`default_nettype none

`include "spi_nor_flash_command_sequencer_macros.svh"

module snf_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [2:0]        command,
   input  wire logic [23:0]       address,
   input  wire logic [15:0]       length,
   input  wire logic [7:0]        data_byte,
   output snf_pkg::batch_type     batch_out
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_READ,
      PH_POLL_PRE,
      PH_PROG,
      PH_POLL_POST
   } phase_type;

   phase_type                           phase_ff, phase_in;
   logic [1:0]                          operation_ff, operation_in;
   logic [23:0]                         address_ff, address_in;
   logic [15:0]                         bytes_left_ff, bytes_left_in;
   logic [snf_pkg::PageCntWidth-1:0]    page_count_ff, page_count_in;
   logic [snf_pkg::PageCntWidth-1:0]    page_next;
   logic [15:0]                         bytes_dec;
   logic [snf_pkg::CountWidth-1:0]      n;
   snf_pkg::batch_type                  batch;

   assign bytes_dec = bytes_left_ff - 16'd1;
   assign page_next = page_count_ff + 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      operation_in  = operation_ff;
      address_in    = address_ff;
      bytes_left_in = bytes_left_ff;
      page_count_in = page_count_ff;
      batch         = '0;
      n             = '0;

      if (phase_ff == PH_IDLE && command == snf_pkg::CMD_READ) begin
         operation_in  = snf_pkg::OP_READ;
         address_in    = address;
         bytes_left_in = length;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEL, snf_pkg::DUMMY_BYTE);  n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_READ);   n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, address[23:16]);      n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, address[15:8]);       n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, address[7:0]);        n = n + 1'b1;
         if (length == 16'd0) begin
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DESEL, 8'h00);  n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DONE, 8'h00);   n = n + 1'b1;
         end else begin
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
            n = n + 1'b1;
            phase_in = PH_READ;
         end
      end else if (phase_ff == PH_IDLE &&
                   (command == snf_pkg::CMD_PROGRAM || command == snf_pkg::CMD_ERASE)) begin
         operation_in  = command[1:0];
         address_in    = address;
         page_count_in = '0;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEL, 8'h00);                n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_WREN);   n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DESEL, 8'h00);              n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEL, 8'h00);                n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_RDSR);   n = n + 1'b1;
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE); n = n + 1'b1;
         phase_in = PH_POLL_PRE;
      end else if (phase_ff == PH_READ && command == snf_pkg::CMD_RXBYTE) begin
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DATA, data_byte);  n = n + 1'b1;
         bytes_left_in = bytes_dec;
         if (bytes_dec == 16'd0) begin
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DESEL, 8'h00);  n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DONE, 8'h00);   n = n + 1'b1;
            phase_in = PH_IDLE;
         end else begin
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
            n = n + 1'b1;
         end
      end else if ((phase_ff == PH_POLL_PRE || phase_ff == PH_POLL_POST) &&
                   command == snf_pkg::CMD_RXBYTE) begin
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DESEL, 8'h00);  n = n + 1'b1;
         if (data_byte[0]) begin
            // Still busy: poll the status register once more.
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEL, 8'h00);  n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_RDSR);
            n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
            n = n + 1'b1;
         end else if (phase_ff == PH_POLL_POST) begin
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DONE, 8'h00);  n = n + 1'b1;
            phase_in = PH_IDLE;
         end else begin
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEL, 8'h00);  n = n + 1'b1;
            if (operation_ff == snf_pkg::OP_PROGRAM) begin
               batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_PROGRAM);
            end else begin
               batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_ERASE);
            end
            n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, address_ff[23:16]);
            n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, address_ff[15:8]);
            n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, address_ff[7:0]);
            n = n + 1'b1;
            if (operation_ff == snf_pkg::OP_PROGRAM) begin
               page_count_in = '0;
               phase_in      = PH_PROG;
            end else begin
               batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DESEL, 8'h00);  n = n + 1'b1;
               batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEL, 8'h00);    n = n + 1'b1;
               batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_RDSR);
               n = n + 1'b1;
               batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
               n = n + 1'b1;
               phase_in = PH_POLL_POST;
            end
         end
      end else if (phase_ff == PH_PROG && command == snf_pkg::CMD_DATA) begin
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, data_byte);  n = n + 1'b1;
         page_count_in = page_next;
         if (page_next >= snf_pkg::PageCntWidth'(snf_pkg::PageBytes)) begin
            // Page complete: close the program command and start polling.
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_DESEL, 8'h00);  n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEL, 8'h00);    n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::OPC_RDSR);
            n = n + 1'b1;
            batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
            n = n + 1'b1;
            phase_in = PH_POLL_POST;
         end
      end else begin
         batch.entry[n] = snf_pkg::make_entry(snf_pkg::KIND_REJECT, 8'h00);  n = n + 1'b1;
      end

      batch.count = n;
   end

   assign batch_out = batch;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         operation_ff  <= snf_pkg::OP_READ;
         address_ff    <= '0;
         bytes_left_ff <= '0;
         page_count_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         operation_ff  <= operation_in;
         address_ff    <= address_in;
         bytes_left_ff <= bytes_left_in;
         page_count_ff <= page_count_in;
      end
   end

   `SNF_ASSERT(a_batch_not_empty, clock, reset, accept |-> (batch_out.count != '0), "request produced no word")
   `SNF_ASSERT(a_prog_op, clock, reset, (phase_ff == PH_PROG) |-> (operation_ff == snf_pkg::OP_PROGRAM), "data phase outside a program")

endmodule

`default_nettype wire

FILE: rtl/snf_emitter.sv
`default_nettype none

`include "spi_nor_flash_command_sequencer_macros.svh"

module snf_emitter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire snf_pkg::batch_type batch_in,
   output logic                    load_ready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [2:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   snf_pkg::batch_type               batch_ff;
   logic [snf_pkg::CountWidth-1:0]   idx_ff;
   logic                             valid_ff;
   logic                             take;
   logic                             finish;

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = batch_ff.entry[idx_ff].kind;
   assign rsp_tdata  = batch_ff.entry[idx_ff].value;
   assign rsp_tlast  = (idx_ff == batch_ff.count - 1'b1);

   assign take       = valid_ff && rsp_tready;
   assign finish     = take && rsp_tlast;
   // A new batch may land in the same cycle the last word of the old one leaves.
   assign load_ready = !valid_ff || finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (finish) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         idx_ff   <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         batch_ff <= batch_in;
      end
   end

   `SNF_ASSERT(a_idx_in_range, clock, reset, valid_ff |-> (idx_ff < batch_ff.count), "word index past batch end")
   `SNF_ASSERT(a_hold_until_last, clock, reset, (valid_ff && !rsp_tlast) |-> !load_ready, "new batch accepted mid-batch")
   `SNF_ASSERT(a_advance, clock, reset, (take && !rsp_tlast) |=> (valid_ff && idx_ff != '0), "batch dropped before last word")

endmodule

`default_nettype wire

FILE: rtl/spi_nor_flash_command_sequencer.sv
// Latency: the first result word of a request is on rsp_* in the cycle after it is accepted.
// Throughput: a request of N words (1 to 10) holds the output register until its last word
// is taken; the next request is taken in the cycle that word leaves, so one request per
// cycle if each yields one word and rsp_tready is high. The output register sets this rate.
// Reset: synchronous, active high; phase returns to idle, counters clear, no word pending.
`default_nettype none

module spi_nor_flash_command_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // address[23:0], length[39:24], data_byte[47:40]
   input  wire logic [2:0]  req_tuser,  // command[2:0]
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // value[7:0]
   output logic [2:0]       rsp_tuser,  // kind[2:0]
   output logic             rsp_tlast   // last word caused by a request
);

   // Each accepted request is decoded in one pass: the decoder moves the phase state
   // and builds the full list of words (chip select, MOSI bytes, read data, done or
   // reject) that the request causes. The emitter holds that list and hands out one
   // word per handshake.

   logic                 accept;
   snf_pkg::batch_type   batch;

   assign accept = req_tvalid && req_tready;

   snf_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_tuser),
      .address   (req_tdata[23:0]),
      .length    (req_tdata[39:24]),
      .data_byte (req_tdata[47:40]),
      .batch_out (batch)
   );

   snf_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .batch_in   (batch),
      .load_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: sim/spi_nor_flash_sequence_checker.sv
// Watches both channels of the flash command sequencer, keeps its own copy of
// the sequencing state and compares every result word with the predicted one.
module spi_nor_flash_sequence_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,  // address[23:0], length[39:24], data_byte[47:40]
   input  wire logic [2:0]  req_tuser,  // command[2:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,  // value[7:0]
   input  wire logic [2:0]  rsp_tuser,  // kind[2:0]
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               words_pending
);

   localparam logic [7:0] STATUS_BUSY = 8'h01;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_POLL_PRE,
      SEQ_PROG,
      SEQ_POLL_POST
   } seq_phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic       last;
   } bus_word_type;

   seq_phase_type phase;
   logic [1:0]    op;
   logic [23:0]   flash_addr;
   logic [15:0]   bytes_left;
   logic [8:0]    page_fill;

   bus_word_type  request_words[$];
   bus_word_type  expected_words[$];

   task automatic emit(input logic [2:0] kind, input logic [7:0] value);
      bus_word_type w;
      w.kind  = kind;
      w.value = value;
      w.last  = 1'b0;
      request_words.push_back(w);
   endtask

   task automatic emit_address();
      emit(snf_pkg::KIND_SEND, flash_addr[23:16]);
      emit(snf_pkg::KIND_SEND, flash_addr[15:8]);
      emit(snf_pkg::KIND_SEND, flash_addr[7:0]);
   endtask

   // Select the chip and clock out the read-status opcode plus one dummy.
   task automatic emit_status_poll();
      emit(snf_pkg::KIND_SEL, 8'h00);
      emit(snf_pkg::KIND_SEND, snf_pkg::OPC_RDSR);
      emit(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
   endtask

   task automatic predict_bus_events(input logic [2:0] cmd, input logic [23:0] addr,
                                     input logic [15:0] len, input logic [7:0] data);
      request_words.delete();
      if (phase == SEQ_IDLE && cmd == snf_pkg::CMD_READ) begin
         op         = snf_pkg::OP_READ;
         flash_addr = addr;
         bytes_left = len;
         emit(snf_pkg::KIND_SEL, 8'h00);
         emit(snf_pkg::KIND_SEND, snf_pkg::OPC_READ);
         emit_address();
         if (len == 16'd0) begin
            emit(snf_pkg::KIND_DESEL, 8'h00);
            emit(snf_pkg::KIND_DONE, 8'h00);
         end else begin
            emit(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
            phase = SEQ_READ;
         end
      end else if (phase == SEQ_IDLE &&
                   (cmd == snf_pkg::CMD_PROGRAM || cmd == snf_pkg::CMD_ERASE)) begin
         op         = (cmd == snf_pkg::CMD_PROGRAM) ? snf_pkg::OP_PROGRAM : snf_pkg::OP_ERASE;
         flash_addr = addr;
         page_fill  = 9'd0;
         emit(snf_pkg::KIND_SEL, 8'h00);
         emit(snf_pkg::KIND_SEND, snf_pkg::OPC_WREN);
         emit(snf_pkg::KIND_DESEL, 8'h00);
         emit_status_poll();
         phase = SEQ_POLL_PRE;
      end else if (phase == SEQ_READ && cmd == snf_pkg::CMD_RXBYTE) begin
         emit(snf_pkg::KIND_DATA, data);
         bytes_left = bytes_left - 16'd1;
         if (bytes_left == 16'd0) begin
            emit(snf_pkg::KIND_DESEL, 8'h00);
            emit(snf_pkg::KIND_DONE, 8'h00);
            phase = SEQ_IDLE;
         end else begin
            emit(snf_pkg::KIND_SEND, snf_pkg::DUMMY_BYTE);
         end
      end else if (phase == SEQ_POLL_PRE && cmd == snf_pkg::CMD_RXBYTE) begin
         emit(snf_pkg::KIND_DESEL, 8'h00);
         if ((data & STATUS_BUSY) != 8'h00) begin
            emit_status_poll();
         end else if (op == snf_pkg::OP_PROGRAM) begin
            emit(snf_pkg::KIND_SEL, 8'h00);
            emit(snf_pkg::KIND_SEND, snf_pkg::OPC_PROGRAM);
            emit_address();
            page_fill = 9'd0;
            phase     = SEQ_PROG;
         end else begin
            emit(snf_pkg::KIND_SEL, 8'h00);
            emit(snf_pkg::KIND_SEND, snf_pkg::OPC_ERASE);
            emit_address();
            emit(snf_pkg::KIND_DESEL, 8'h00);
            emit_status_poll();
            phase = SEQ_POLL_POST;
         end
      end else if (phase == SEQ_PROG && cmd == snf_pkg::CMD_DATA) begin
         emit(snf_pkg::KIND_SEND, data);
         page_fill = page_fill + 9'd1;
         if (page_fill >= snf_pkg::PageBytes) begin
            emit(snf_pkg::KIND_DESEL, 8'h00);
            emit_status_poll();
            phase = SEQ_POLL_POST;
         end
      end else if (phase == SEQ_POLL_POST && cmd == snf_pkg::CMD_RXBYTE) begin
         emit(snf_pkg::KIND_DESEL, 8'h00);
         if ((data & STATUS_BUSY) != 8'h00) begin
            emit_status_poll();
         end else begin
            emit(snf_pkg::KIND_DONE, 8'h00);
            phase = SEQ_IDLE;
         end
      end else begin
         emit(snf_pkg::KIND_REJECT, 8'h00);
      end
      request_words[request_words.size()-1].last = 1'b1;
      foreach (request_words[i]) expected_words.push_back(request_words[i]);
   endtask

   task automatic check_word();
      bus_word_type want;
      if (expected_words.size() == 0) begin
         $display("%0t checker: unexpected word kind %0d value %02h last %0b, none expected",
                  $time, rsp_tuser, rsp_tdata, rsp_tlast);
         fail_count++;
      end else begin
         want = expected_words.pop_front();
         if (rsp_tuser !== want.kind) begin
            $display("%0t checker: kind expected %0d, got %0d", $time, want.kind, rsp_tuser);
            fail_count++;
         end
         if (rsp_tdata !== want.value) begin
            $display("%0t checker: value expected %02h, got %02h", $time, want.value, rsp_tdata);
            fail_count++;
         end
         if (rsp_tlast !== want.last) begin
            $display("%0t checker: last expected %0b, got %0b", $time, want.last, rsp_tlast);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = SEQ_IDLE;
         op         = snf_pkg::OP_READ;
         flash_addr = 24'd0;
         bytes_left = 16'd0;
         page_fill  = 9'd0;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_bus_events(req_tuser, req_tdata[23:0], req_tdata[39:24], req_tdata[47:40]);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_word();
         end
      end
      words_pending = expected_words.size();
   end

endmodule

FILE: sim/tb.sv
// Top of the flash command sequencer testbench. It drives request words,
// throttles the result channel, and reports the verdict; all prediction and
// comparison lives in the checker instantiated next to the block.
module tb;

   // Commands the block never accepts in any phase.
   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
   // Bit 0 of the status register is the write-in-progress flag.
   localparam logic [7:0] STATUS_BUSY      = 8'h01;
   localparam int         TOTAL_REQUESTS   = 380;

   // Where the host side believes the flash transaction stands. It decides
   // which commands move a transaction forward and which ones are noise.
   typedef enum logic [1:0] {
      AT_IDLE,
      AT_READ,
      AT_POLL,
      AT_PROG
   } host_stage_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = 48'd0;  // address[23:0], length[39:24], data_byte[47:40]
   logic [2:0]  req_tuser  = 3'd0;   // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // value[7:0]
   logic [2:0]  rsp_tuser;           // kind[2:0]
   logic        rsp_tlast;

   int          fail_count;
   int          words_pending;
   int          tx_idle_pct   = 0;
   int          rx_idle_pct   = 0;
   int          requests_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   spi_nor_flash_command_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   spi_nor_flash_sequence_checker seq_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   // The result side stalls at random; the percentage changes between phases
   // of the run so that stalls land on every kind of word the block emits.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Hard stop in case the block hangs or drops a handshake.
   initial begin
      #15_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // The first third of the run has a busy sender and a slow receiver, the
   // second third the other way round, and the rest runs at full rate.
   task automatic set_idle_mix();
      if (requests_sent < TOTAL_REQUESTS / 3) begin
         tx_idle_pct = 11;
         rx_idle_pct = 83;
      end else if (requests_sent < 2 * TOTAL_REQUESTS / 3) begin
         tx_idle_pct = 83;
         rx_idle_pct = 11;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endtask

   // One request word. The sender may first hold tvalid low at random;
   // once tvalid is up it stays up until the word is taken. The iff samples
   // tready as it was just before the edge, so the handshake is race free.
   task automatic issue_request(input logic [2:0] cmd, input logic [23:0] addr,
                                input logic [15:0] len, input logic [7:0] data);
      set_idle_mix();
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {data, len, addr};
      @(posedge clock iff req_tready);
      requests_sent++;
   endtask

   function automatic bit accepted_in(host_stage_type stage, logic [2:0] cmd);
      case (stage)
         AT_IDLE: return cmd == snf_pkg::CMD_READ || cmd == snf_pkg::CMD_PROGRAM ||
                         cmd == snf_pkg::CMD_ERASE;
         AT_PROG: return cmd == snf_pkg::CMD_DATA;
         default: return cmd == snf_pkg::CMD_RXBYTE;
      endcase
   endfunction

   // A word the block must turn away in this stage, with random fields, so it
   // leaves the transaction in progress untouched.
   task automatic send_reject(input host_stage_type stage);
      logic [2:0] cmd;
      do begin
         cmd = 3'($urandom_range(7));
      end while (accepted_in(stage, cmd));
      issue_request(cmd, 24'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic maybe_noise(input host_stage_type stage);
      if ($urandom_range(99) < 8) begin
         send_reject(stage);
      end
   endtask

   task automatic rx_byte(input logic [7:0] data);
      issue_request(snf_pkg::CMD_RXBYTE, 24'($urandom), 16'($urandom), data);
   endtask

   // Answer status polls: zero to two busy readings, then one with the flag clear.
   task automatic await_not_busy();
      int busy_polls;
      busy_polls = $urandom_range(0, 2);
      repeat (busy_polls) begin
         maybe_noise(AT_POLL);
         rx_byte(8'($urandom) | STATUS_BUSY);
      end
      maybe_noise(AT_POLL);
      rx_byte(8'($urandom) & ~STATUS_BUSY);
   endtask

   task automatic run_read(input logic [23:0] addr, input logic [15:0] len);
      int i;
      maybe_noise(AT_IDLE);
      issue_request(snf_pkg::CMD_READ, addr, len, 8'($urandom));
      for (i = 0; i < int'(len); i++) begin
         maybe_noise(AT_READ);
         rx_byte(8'($urandom));
      end
   endtask

   // A page program always carries one stray received byte during the data
   // phase, which the block must refuse without counting it as data.
   task automatic run_program(input logic [23:0] addr);
      int i;
      maybe_noise(AT_IDLE);
      issue_request(snf_pkg::CMD_PROGRAM, addr, 16'($urandom), 8'($urandom));
      await_not_busy();
      rx_byte(8'($urandom));
      for (i = 0; i < snf_pkg::PageBytes; i++) begin
         maybe_noise(AT_PROG);
         issue_request(snf_pkg::CMD_DATA, 24'($urandom), 16'($urandom), 8'($urandom));
      end
      await_not_busy();
   endtask

   task automatic run_erase(input logic [23:0] addr);
      maybe_noise(AT_IDLE);
      issue_request(snf_pkg::CMD_ERASE, addr, 16'($urandom), 8'($urandom));
      await_not_busy();
      await_not_busy();
   endtask

   initial begin
      int pick;
      int len;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words. Anything but a start is turned away while idle.
      issue_request(snf_pkg::CMD_DATA, 24'h000000, 16'h0000, 8'h00);
      issue_request(snf_pkg::CMD_RXBYTE, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      issue_request(CMD_FIRST_UNUSED, 24'h5A5A5A, 16'hA5A5, 8'h5A);
      issue_request(CMD_LAST_UNUSED, 24'hA5A5A5, 16'h5A5A, 8'hA5);

      // A zero-length read finishes entirely on its start word.
      issue_request(snf_pkg::CMD_READ, 24'hFFFFFF, 16'h0000, 8'h00);

      // Two-byte read at the bottom of the array, with a start and a data
      // word thrown in while the read is still open.
      issue_request(snf_pkg::CMD_READ, 24'h000000, 16'd2, 8'hFF);
      issue_request(snf_pkg::CMD_ERASE, 24'h123456, 16'd0, 8'h00);
      issue_request(snf_pkg::CMD_DATA, 24'h000000, 16'd0, 8'h3C);
      rx_byte(8'hFF);
      rx_byte(8'h00);

      // Sector erase at the top address with one busy reading before the
      // erase opcode and one after it, plus words refused while polling.
      issue_request(snf_pkg::CMD_ERASE, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      rx_byte(8'hFF);
      rx_byte(8'h00);
      issue_request(snf_pkg::CMD_DATA, 24'h000000, 16'd0, 8'h77);
      issue_request(snf_pkg::CMD_PROGRAM, 24'h000000, 16'd0, 8'h00);
      rx_byte(8'h01);
      rx_byte(8'hFE);

      // Random part. It opens with a full page program and then mixes reads
      // (mostly short), erases and bursts of noise.
      run_program(24'($urandom));
      while (requests_sent < TOTAL_REQUESTS) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            len = $urandom_range(99);
            if (len < 8) begin
               len = 0;
            end else if (len < 85) begin
               len = $urandom_range(1, 6);
            end else begin
               len = $urandom_range(7, 40);
            end
            run_read(24'($urandom), 16'(len));
         end else if (pick < 80) begin
            run_erase(24'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) send_reject(AT_IDLE);
         end
      end

      req_tvalid <= 1'b0;
      // Let the checker book the last accepted word before waiting on words_pending.
      @(posedge clock);
      wait (words_pending == 0);
      repeat (16) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
